/* src/union_find_engine_assert.svh */
// Assertion macros shared by the union-find engine modules
`ifndef UNION_FIND_ENGINE_ASSERT_SVH
`define UNION_FIND_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define UFE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UFE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ufe_pkg.sv */
// Types and constants shared by the union-find engine modules
package ufe_pkg;

    localparam int unsigned ELEM_W        = 10;
    localparam int unsigned CNT_W         = 11;
    localparam int unsigned RANK_W        = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam int unsigned MAX_ELEMS_DEF = 1024;
    localparam logic [CNT_W-1:0] NUM_ELEMS_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_UNION = 2'd1,
        OP_FIND  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_INIT_STEP,
        DP_INIT_END,
        DP_WALK_START,
        DP_WALK,
        DP_COMP,
        DP_SAVE,
        DP_RANK_A,
        DP_RANK_B,
        DP_LINK,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   use_b;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic par_self;
        logic start_root;
        logic comp_end;
        logic sweep_last;
        logic init_empty;
        logic roots_eq;
    } dp_status_t;

endpackage

/* src/union_find_engine.sv */
// Union-find engine top level: sequencer plus datapath
//
// Disjoint-set engine with union by rank and path compression.
// Input channel s_*: op (init, union, find), elem_a, elem_b; one result per item.
// Result channel m_*: root, merged, components, error, held in an output
// register, so the next item is taken while a result still waits for m_ready.
// Config channel cfg_*: num_elems, used by the next init and by the index
// check; always ready.
// Init writes one parent/rank entry per cycle; a union whose roots match
// skips the rank and link steps; an error or unused opcode goes straight to
// the result.
// One item is processed at a time; the walk is paced by the single read port
// of the parent memory, one link per cycle, and the write-back by its one
// write port.
// Reset clears the set count and the initialized size; the memories are not
// cleared, and find/union report error until an init has run.
// If m_ready stays low, the finished item waits in its final state and
// s_ready stays low until the output register frees up.

module union_find_engine import ufe_pkg::*; #(
    parameter int unsigned MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_num_elems,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [ELEM_W-1:0] s_elem_a,
    input  logic [ELEM_W-1:0] s_elem_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ELEM_W-1:0] m_root,
    output logic              m_merged,
    output logic [CNT_W-1:0]  m_components,
    output logic              m_error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ufe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ufe_datapath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_num_elems (cfg_num_elems),
        .s_op          (s_op),
        .s_elem_a      (s_elem_a),
        .s_elem_b      (s_elem_b),
        .m_root        (m_root),
        .m_merged      (m_merged),
        .m_components  (m_components),
        .m_error       (m_error)
    );

endmodule

/* src/ufe_ctrl.sv */
// Sequencer for the union-find engine: issues datapath commands per operation
`include "union_find_engine_assert.svh"

module ufe_ctrl import ufe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_DECODE   = 12'b000000000010,
        S_SWEEP    = 12'b000000000100,
        S_INIT_END = 12'b000000001000,
        S_WALK     = 12'b000000010000,
        S_COMP     = 12'b000000100000,
        S_FOUND    = 12'b000001000000,
        S_BSTART   = 12'b000010000000,
        S_RANK_A   = 12'b000100000000,
        S_RANK_B   = 12'b001000000000,
        S_LINK     = 12'b010000000000,
        S_DONE     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   b_phase_reg, b_phase_next;
    logic   m_valid_reg;
    logic   load_out;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        b_phase_next = b_phase_reg;
        cmd.op       = DP_NONE;
        cmd.use_b    = b_phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op       = DP_LOAD;
                    b_phase_next = 1'b0;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (status.op) inside
                    OP_INIT: begin
                        state_next = status.init_empty ? S_INIT_END : S_SWEEP;
                    end
                    OP_UNION, OP_FIND: begin
                        if (status.err) begin
                            state_next = S_DONE;
                        end else begin
                            cmd.op     = DP_WALK_START;
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SWEEP: begin
                cmd.op = DP_INIT_STEP;
                if (status.sweep_last) begin
                    state_next = S_INIT_END;
                end
            end
            S_INIT_END: begin
                cmd.op     = DP_INIT_END;
                state_next = S_DONE;
            end
            S_WALK: begin
                cmd.op = DP_WALK;
                if (status.par_self) begin
                    state_next = status.start_root ? S_FOUND : S_COMP;
                end
            end
            S_COMP: begin
                cmd.op = DP_COMP;
                if (status.comp_end) begin
                    state_next = S_FOUND;
                end
            end
            S_FOUND: begin
                cmd.op = DP_SAVE;
                if (b_phase_reg) begin
                    state_next = S_RANK_A;
                end else if (status.op == OP_UNION) begin
                    b_phase_next = 1'b1;
                    state_next   = S_BSTART;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_BSTART: begin
                cmd.op     = DP_WALK_START;
                state_next = S_WALK;
            end
            S_RANK_A: begin
                if (status.roots_eq) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_RANK_A;
                    state_next = S_RANK_B;
                end
            end
            S_RANK_B: begin
                cmd.op     = DP_RANK_B;
                state_next = S_LINK;
            end
            S_LINK: begin
                cmd.op     = DP_LINK;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            b_phase_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            b_phase_reg <= b_phase_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // a finished result must land in the output register
    `UFE_ASSERT_NEXT(a_result_shown, aclk, aresetn, load_out, m_valid_reg, "result not presented")
    // second root walk only happens for a union
    `UFE_ASSERT_SAME(a_bphase_union, aclk, aresetn, b_phase_reg && (state_reg != S_IDLE), status.op == OP_UNION, "second walk outside union")
    // an accepted item must take the sequencer into decode
    `UFE_ASSERT_NEXT(a_busy_after_load, aclk, aresetn, s_valid && s_ready, state_reg == S_DECODE, "load did not start decode")

endmodule

/* src/ufe_datapath.sv */
// Datapath for the union-find engine: parent/rank memories, walk registers, counters
`include "union_find_engine_assert.svh"

module ufe_datapath import ufe_pkg::*; #(
    parameter int unsigned MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_num_elems,
    input  logic [1:0]        s_op,
    input  logic [ELEM_W-1:0] s_elem_a,
    input  logic [ELEM_W-1:0] s_elem_b,
    output logic [ELEM_W-1:0] m_root,
    output logic              m_merged,
    output logic [CNT_W-1:0]  m_components,
    output logic              m_error
);

    localparam int unsigned ADDR_W = $clog2(MAX_ELEMS);
    localparam int unsigned CNT_MAX = (2 ** CNT_W) - 1;
    localparam int unsigned CLAMP = (MAX_ELEMS > CNT_MAX) ? CNT_MAX : MAX_ELEMS;
    localparam logic [CNT_W-1:0] N_CLAMP = CNT_W'(CLAMP);

    logic [ADDR_W-1:0] parent_mem [MAX_ELEMS];
    logic [RANK_W-1:0] rank_mem   [MAX_ELEMS];

    logic [CNT_W-1:0]  num_elems_reg, set_count_reg, init_size_reg;
    op_t               op_reg;
    logic [ELEM_W-1:0] a_reg, b_reg;
    logic              err_reg;
    logic [CNT_W-1:0]  sweep_reg;
    logic [ADDR_W-1:0] cur_reg, start_reg, x_reg, root_reg, ra_reg, rb_reg;
    logic [RANK_W-1:0] rank_a_reg;
    logic [ELEM_W-1:0] res_root_reg;
    logic              res_merged_reg;
    logic [ELEM_W-1:0] m_root_reg;
    logic              m_merged_reg;
    logic [CNT_W-1:0]  m_components_reg;
    logic              m_error_reg;
    logic [ADDR_W-1:0] par_rdata_reg;
    logic [RANK_W-1:0] rank_rdata_reg;

    logic [CNT_W-1:0]  n_clamp, lim;
    logic              load_err;
    logic [ADDR_W-1:0] sel_elem;
    logic              par_self, rank_lt, rank_eq;
    logic              par_we, rank_we;
    logic [ADDR_W-1:0] par_waddr, par_wdata, par_raddr;
    logic [ADDR_W-1:0] rank_waddr, rank_raddr;
    logic [RANK_W-1:0] rank_wdata;

    assign n_clamp  = (num_elems_reg > N_CLAMP) ? N_CLAMP : num_elems_reg;
    assign lim      = (n_clamp > init_size_reg) ? init_size_reg : n_clamp;
    assign sel_elem = cmd.use_b ? ADDR_W'(b_reg) : ADDR_W'(a_reg);
    assign par_self = (par_rdata_reg == cur_reg);
    assign rank_lt  = (rank_a_reg < rank_rdata_reg);
    assign rank_eq  = (rank_a_reg == rank_rdata_reg);

    always_comb begin
        load_err = 1'b0;
        case (op_t'(s_op))
            OP_UNION: load_err = (CNT_W'(s_elem_a) >= lim) || (CNT_W'(s_elem_b) >= lim);
            OP_FIND:  load_err = (CNT_W'(s_elem_a) >= lim);
            default:  load_err = 1'b0;
        endcase
    end

    assign status.op         = op_reg;
    assign status.err        = err_reg;
    assign status.par_self   = par_self;
    assign status.start_root = (start_reg == cur_reg);
    assign status.comp_end   = (par_rdata_reg == root_reg);
    assign status.sweep_last = (sweep_reg == (n_clamp - CNT_W'(1)));
    assign status.init_empty = (n_clamp == '0);
    assign status.roots_eq   = (ra_reg == rb_reg);

    // memory port steering
    always_comb begin
        par_we     = 1'b0;
        par_waddr  = x_reg;
        par_wdata  = root_reg;
        par_raddr  = cur_reg;
        rank_we    = 1'b0;
        rank_waddr = ra_reg;
        rank_wdata = rank_a_reg + RANK_W'(1);
        rank_raddr = ra_reg;
        unique case (cmd.op)
            DP_INIT_STEP: begin
                par_we     = 1'b1;
                par_waddr  = ADDR_W'(sweep_reg);
                par_wdata  = ADDR_W'(sweep_reg);
                rank_we    = 1'b1;
                rank_waddr = ADDR_W'(sweep_reg);
                rank_wdata = '0;
            end
            DP_WALK_START: par_raddr = sel_elem;
            DP_WALK:       par_raddr = par_self ? start_reg : par_rdata_reg;
            DP_COMP: begin
                par_we    = 1'b1;
                par_raddr = par_rdata_reg;
            end
            DP_RANK_A: rank_raddr = ra_reg;
            DP_RANK_B: rank_raddr = rb_reg;
            DP_LINK: begin
                par_we    = 1'b1;
                par_waddr = rank_lt ? ra_reg : rb_reg;
                par_wdata = rank_lt ? rb_reg : ra_reg;
                rank_we   = !rank_lt && rank_eq && (rank_a_reg != RANK_MAX);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (par_we) begin
            parent_mem[par_waddr] <= par_wdata;
        end
        par_rdata_reg <= parent_mem[par_raddr];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_rdata_reg <= rank_mem[rank_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_elems_reg <= NUM_ELEMS_RST;
            set_count_reg <= '0;
            init_size_reg <= '0;
        end else begin
            if (cfg_we) begin
                num_elems_reg <= cfg_num_elems;
            end
            if (cmd.op == DP_INIT_END) begin
                init_size_reg <= n_clamp;
                set_count_reg <= n_clamp;
            end else if ((cmd.op == DP_LINK) && (set_count_reg != '0)) begin
                set_count_reg <= set_count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                op_reg         <= op_t'(s_op);
                a_reg          <= s_elem_a;
                b_reg          <= s_elem_b;
                err_reg        <= load_err;
                sweep_reg      <= '0;
                res_root_reg   <= '0;
                res_merged_reg <= 1'b0;
            end
            DP_INIT_STEP: sweep_reg <= sweep_reg + CNT_W'(1);
            DP_WALK_START: begin
                cur_reg   <= sel_elem;
                start_reg <= sel_elem;
            end
            DP_WALK: begin
                if (par_self) begin
                    root_reg <= cur_reg;
                    x_reg    <= start_reg;
                end else begin
                    cur_reg <= par_rdata_reg;
                end
            end
            DP_COMP: x_reg <= par_rdata_reg;
            DP_SAVE: begin
                if (cmd.use_b) begin
                    rb_reg <= root_reg;
                end else begin
                    ra_reg       <= root_reg;
                    res_root_reg <= ELEM_W'(root_reg);
                end
            end
            DP_RANK_B: rank_a_reg <= rank_rdata_reg;
            DP_LINK: begin
                res_merged_reg <= 1'b1;
                res_root_reg   <= rank_lt ? ELEM_W'(rb_reg) : ELEM_W'(ra_reg);
            end
            DP_RESULT: begin
                m_root_reg       <= res_root_reg;
                m_merged_reg     <= res_merged_reg;
                m_components_reg <= set_count_reg;
                m_error_reg      <= err_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_root       = m_root_reg;
    assign m_merged     = m_merged_reg;
    assign m_components = m_components_reg;
    assign m_error      = m_error_reg;

    `UFE_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, set_count_reg <= init_size_reg, "set count exceeds initialized size")
    // compression must never repoint the root itself
    `UFE_ASSERT_SAME(a_comp_not_root, aclk, aresetn, cmd.op == DP_COMP, x_reg != root_reg, "compression wrote the root")
    `UFE_ASSERT_SAME(a_link_distinct, aclk, aresetn, cmd.op == DP_LINK, ra_reg != rb_reg, "link of a root to itself")

endmodule
